FILE: hw/rtl/slist_pkg.sv
// Shared types, codes and defaults for the sorted key list.
package slist_pkg;

   localparam int DEPTH_DEF     = 64;
   localparam int KEY_WIDTH_DEF = 32;
   localparam int KEY_FIELD_W   = 32;
   localparam int POS_FIELD_W   = 6;
   localparam int COUNT_FIELD_W = 7;
   localparam int CAP_W         = 7;
   localparam int CSR_ADDR_W    = 2;
   localparam int CSR_DATA_W    = 32;

   localparam logic [CAP_W-1:0]      CAP_RESET = CAP_W'(64);
   localparam logic [CSR_ADDR_W-1:0] CAP_ADDR  = CSR_ADDR_W'(0);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      op_type                   opcode;
      logic [KEY_FIELD_W-1:0]   key;
      logic [POS_FIELD_W-1:0]   position;
   } req_type;

   typedef struct packed {
      logic [KEY_FIELD_W-1:0]   read_key;
      logic [COUNT_FIELD_W-1:0] count;
      status_type               status;
   } rsp_type;

   // Shift commands broadcast to every cell.
   typedef struct packed {
      logic ins;
      logic rem;
   } ctl_type;

endpackage

FILE: hw/rtl/slist_cell.sv
// One list slot: holds a key and shifts toward either neighbor on command.
module slist_cell import slist_pkg::*; #(
   parameter int KEY_WIDTH = KEY_WIDTH_DEF,
   parameter int IDX_W     = 6,
   parameter int CNT_W     = 7,
   parameter int INDEX     = 0
) (
   input  logic                 clock,
   input  ctl_type              ctl,
   input  logic [KEY_WIDTH-1:0] ins_key,
   input  logic [IDX_W-1:0]     rem_pos,
   input  logic [CNT_W-1:0]     fill,
   input  logic                 left_lt,
   input  logic [KEY_WIDTH-1:0] left_key,
   input  logic [KEY_WIDTH-1:0] right_key,
   output logic [KEY_WIDTH-1:0] key_out,
   output logic                 lt_out
);

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;
   logic                 below_fill;

   assign below_fill = CNT_W'(INDEX) < fill;
   // Held keys below the new one stay; the first other slot takes the new key.
   assign lt_out     = below_fill && (key_ff < ins_key);
   assign key_out    = key_ff;

   always_comb begin
      key_in = key_ff;
      if (ctl.ins && !lt_out) begin
         key_in = left_lt ? ins_key : left_key;
      end else if (ctl.rem && (IDX_W'(INDEX) >= rem_pos)) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

FILE: hw/rtl/slist_chain.sv
// Row of list cells with neighbor links and the lookup read port.
module slist_chain import slist_pkg::*; #(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int KEY_WIDTH = KEY_WIDTH_DEF,
   parameter int IDX_W     = $clog2(DEPTH),
   parameter int CNT_W     = $clog2(DEPTH + 1)
) (
   input  logic                 clock,
   input  ctl_type              ctl,
   input  logic [KEY_WIDTH-1:0] ins_key,
   input  logic [IDX_W-1:0]     pos,
   input  logic [CNT_W-1:0]     fill,
   output logic [KEY_WIDTH-1:0] look_key
);

   logic [KEY_WIDTH-1:0] keys [DEPTH];
   logic                 lts  [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                 left_lt;
      logic [KEY_WIDTH-1:0] left_key;
      logic [KEY_WIDTH-1:0] right_key;

      if (i == 0) begin : g_head
         // Head slot has nothing below it: it takes the new key directly.
         assign left_lt  = 1'b1;
         assign left_key = ins_key;
      end else begin : g_body
         assign left_lt  = lts[i-1];
         assign left_key = keys[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_key = keys[i];
      end else begin : g_inner
         assign right_key = keys[i+1];
      end

      slist_cell #(
         .KEY_WIDTH (KEY_WIDTH),
         .IDX_W     (IDX_W),
         .CNT_W     (CNT_W),
         .INDEX     (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .ins_key   (ins_key),
         .rem_pos   (pos),
         .fill      (fill),
         .left_lt   (left_lt),
         .left_key  (left_key),
         .right_key (right_key),
         .key_out   (keys[i]),
         .lt_out    (lts[i])
      );
   end

   assign look_key = keys[pos];

endmodule

FILE: hw/rtl/sorted_list_insert_remove_unit.sv
// Sorted key list: keeps unsigned keys in ascending order in a row of cells.
//
// Input channel req_*: one beat carries an opcode (insert, lookup, remove or
// no-op), a key for inserts and a position for lookups and removes. Result
// channel rsp_*: exactly one beat per input beat, in order, carrying the key
// read by a lookup, the count after the operation and a status (ok, full,
// index out of range).
// Results are registered: rsp_valid rises in the cycle after acceptance.
// Every cell compares and shifts in the same cycle, so one beat is taken per
// cycle when not stalled; the single output register is the only stage.
// When rsp_stall is high while a result is waiting, the result register holds
// and req_stall rises, so no new beat is taken until that result is accepted.
// Reset empties the list at once (count zero, no clearing pass) and sets
// capacity to 64. Capacity must be written over the csr_* port at address 0
// only while idle, unchecked by the block; values above DEPTH act as DEPTH.
module sorted_list_insert_remove_unit import slist_pkg::*; #(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   logic [CAP_W-1:0]     cap_ff;
   logic [CAP_W-1:0]     cap_in;
   logic [CNT_W-1:0]     fill_ff;
   logic [CNT_W-1:0]     fill_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_type              rsp_data_ff;
   rsp_type              rsp_data_in;

   logic                 accept;
   logic                 full;
   logic                 pos_ok;
   logic [CMP_W-1:0]     fill_w;
   logic [CMP_W-1:0]     fill_next_w;
   ctl_type              ctl;
   logic [KEY_WIDTH+KEY_FIELD_W-1:0] key_wide;
   logic [KEY_WIDTH-1:0] ins_key;
   logic [IDX_W+POS_FIELD_W-1:0]     pos_wide;
   logic [IDX_W-1:0]     pos_idx;
   logic [KEY_WIDTH-1:0] look_key;
   logic [KEY_WIDTH+KEY_FIELD_W-1:0] look_wide;
   logic                 csr_wr;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && (csr_paddr == CAP_ADDR);
   assign cap_in     = csr_wr ? csr_pwdata[CAP_W-1:0] : cap_ff;
   assign csr_prdata = (csr_paddr == CAP_ADDR) ? CSR_DATA_W'(cap_ff) : '0;

   // Handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Operand shaping
   assign key_wide  = {KEY_WIDTH'(0), req_data.key};
   assign ins_key   = key_wide[KEY_WIDTH-1:0];
   assign pos_wide  = {IDX_W'(0), req_data.position};
   assign pos_idx   = pos_wide[IDX_W-1:0];
   assign look_wide = {KEY_FIELD_W'(0), look_key};

   assign fill_w = CMP_W'(fill_ff);
   assign full   = (fill_w >= CMP_W'(cap_ff)) || (fill_w >= CMP_W'(DEPTH));
   assign pos_ok = CMP_W'(req_data.position) < fill_w;

   always_comb begin
      ctl                  = '0;
      fill_next_w          = fill_w;
      rsp_data_in.read_key = '0;
      rsp_data_in.status   = ST_OK;
      unique case (req_data.opcode)
         OP_INSERT: begin
            if (full) begin
               rsp_data_in.status = ST_FULL;
            end else begin
               ctl.ins     = accept;
               fill_next_w = fill_w + CMP_W'(1);
            end
         end
         OP_LOOKUP: begin
            if (pos_ok) begin
               rsp_data_in.read_key = look_wide[KEY_FIELD_W-1:0];
            end else begin
               rsp_data_in.status = ST_RANGE;
            end
         end
         OP_REMOVE: begin
            if (pos_ok) begin
               ctl.rem     = accept;
               fill_next_w = fill_w - CMP_W'(1);
            end else begin
               rsp_data_in.status = ST_RANGE;
            end
         end
         OP_NOP: begin
            fill_next_w = fill_w;
         end
         default: begin
            fill_next_w = fill_w;
         end
      endcase
      rsp_data_in.count = fill_next_w[COUNT_FIELD_W-1:0];
   end

   assign fill_in      = accept ? fill_next_w[CNT_W-1:0] : fill_ff;
   // Hold a stalled result; drop it once taken.
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   slist_chain #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W)
   ) u_chain (
      .clock    (clock),
      .ctl      (ctl),
      .ins_key  (ins_key),
      .pos      (pos_idx),
      .fill     (fill_ff),
      .look_key (look_key)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(fill_ff) <= CMP_W'(DEPTH))
      else $error("fill count above depth");

   a_refused_insert: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.opcode == OP_INSERT) && full |=> $stable(fill_ff))
      else $error("refused insert changed fill");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.opcode == OP_REMOVE) && pos_ok
      |=> fill_ff == $past(fill_ff) - CNT_W'(1))
      else $error("remove did not drop fill by one");

   a_err_zero_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status != ST_OK) |-> rsp_data_ff.read_key == '0)
      else $error("error result carries a key");
`endif

endmodule

FILE: tb/sv/sorted_list_insert_remove_unit_tb.sv
// Self-checking testbench for the sorted key list: directed and random ops vs a shadow list.
`timescale 1ns / 100ps

module sorted_list_insert_remove_unit_tb;
   import slist_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // shadow copy of the list
   logic [KEY_FIELD_W-1:0] list_keys [DEPTH_DEF];
   int                     list_fill = 0;
   logic [CAP_W-1:0]       list_capacity = CAP_RESET;

   req_type pending_ops[$];
   rsp_type expected_results[$];

   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic req_taken     = 1'b0;
   int   idle_cycles   = 0;
   int   mismatches    = 0;

   sorted_list_insert_remove_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int cap_limit();
      return (list_capacity > DEPTH_DEF) ? DEPTH_DEF : int'(list_capacity);
   endfunction

   // Apply one op to the shadow list and return the result it must produce.
   function automatic rsp_type apply_list_op(req_type beat);
      rsp_type r;
      int      slot;
      int      k;
      r.read_key = '0;
      r.status   = ST_OK;
      case (beat.opcode)
         OP_INSERT: begin
            if (list_fill >= cap_limit()) begin
               r.status = ST_FULL;
            end else begin
               slot = 0;
               while (slot < list_fill && list_keys[slot] < beat.key) slot++;
               for (k = list_fill; k > slot; k--) list_keys[k] = list_keys[k-1];
               list_keys[slot] = beat.key;
               list_fill++;
            end
         end
         OP_LOOKUP: begin
            if (beat.position >= list_fill) r.status = ST_RANGE;
            else r.read_key = list_keys[beat.position];
         end
         OP_REMOVE: begin
            if (beat.position >= list_fill) begin
               r.status = ST_RANGE;
            end else begin
               for (k = beat.position; k + 1 < list_fill; k++) list_keys[k] = list_keys[k+1];
               list_fill--;
            end
         end
         default: ;
      endcase
      r.count = COUNT_FIELD_W'(list_fill);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch %0d at %0t: %s got 0x%0h want 0x%0h",
               mismatches, $realtime, what, got, want);
   endtask

   // Driver: advance to the next beat once the current one is taken, hold it otherwise.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= pending_ops.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Monitor: predict on every accepted request, check every accepted result.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            expected_results.push_back(apply_list_op(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result beat with none expected", rsp_data.read_key, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.read_key !== want.read_key)
                  report_mismatch("read_key", rsp_data.read_key, want.read_key);
               if (rsp_data.count !== want.count)
                  report_mismatch("count", 32'(rsp_data.count), 32'(want.count));
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic push_op(op_type op, logic [KEY_FIELD_W-1:0] key,
                          logic [POS_FIELD_W-1:0] pos);
      req_type beat;
      beat.opcode   = op;
      beat.key      = key;
      beat.position = pos;
      pending_ops.push_back(beat);
   endtask

   // Sampled at the rising edge, where the queue and req_valid only move on the falling edge.
   task automatic wait_drained();
      @(posedge clock);
      while (pending_ops.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic check_capacity();
      @(negedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_paddr  <= CAP_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[CAP_W-1:0] !== list_capacity)
         report_mismatch("capacity readback", 32'(csr_prdata[CAP_W-1:0]), 32'(list_capacity));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Change capacity only with the list idle, then read it back.
   task automatic set_capacity(int value);
      wait_drained();
      @(negedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= CAP_ADDR;
      csr_pwdata <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      list_capacity = CAP_W'(value);
      check_capacity();
   endtask

   // Mostly in-range positions so the list fills and drains; the rest is noise.
   task automatic run_phase(int cap, int idle_pct, int hold_pct, int n, int ins_pct);
      req_type beat;
      int      plan_fill;
      int      lim;
      int      i;
      int      r;
      set_capacity(cap);
      send_idle_pct = idle_pct;
      rsp_stall_pct = hold_pct;
      plan_fill = list_fill;
      lim = cap_limit();
      for (i = 0; i < n; i++) begin
         r = $urandom_range(99);
         case ($urandom_range(3))
            0:       beat.key = KEY_FIELD_W'($urandom_range(15));
            1:       beat.key = 32'hFFFF_FFF0 | KEY_FIELD_W'($urandom_range(15));
            default: beat.key = $urandom();
         endcase
         if ($urandom_range(99) < 85 && plan_fill > 0)
            beat.position = POS_FIELD_W'($urandom_range(plan_fill - 1));
         else
            beat.position = POS_FIELD_W'($urandom_range(63));
         if (r < 4) begin
            beat.opcode = OP_NOP;
         end else if (r < 4 + ins_pct) begin
            beat.opcode = OP_INSERT;
            if (plan_fill < lim) plan_fill++;
         end else if (r[0]) begin
            beat.opcode = OP_LOOKUP;
         end else begin
            beat.opcode = OP_REMOVE;
            if (beat.position < plan_fill) plan_fill--;
         end
         pending_ops.push_back(beat);
      end
      // hold off until every result of this phase is back
      wait_drained();
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      check_capacity();

      // empty list, extreme keys, equal keys, ordering, out-of-range indexes
      push_op(OP_LOOKUP, '0, '0);
      push_op(OP_REMOVE, '0, '0);
      push_op(OP_INSERT, 32'hFFFF_FFFF, '0);
      push_op(OP_INSERT, 32'h0000_0000, '1);
      push_op(OP_INSERT, 32'h8000_0000, '0);
      push_op(OP_INSERT, 32'h8000_0000, '0);
      push_op(OP_INSERT, 32'h7FFF_FFFF, '0);
      for (int p = 0; p < 5; p++) push_op(OP_LOOKUP, '1, POS_FIELD_W'(p));
      push_op(OP_LOOKUP, '0, '1);
      push_op(OP_REMOVE, '0, '1);
      push_op(OP_NOP, '1, '1);
      push_op(OP_REMOVE, '1, 6'd2);
      push_op(OP_REMOVE, '0, 6'd3);

      // capacity dropped below the count: inserts refused until removes catch up
      set_capacity(2);
      push_op(OP_INSERT, 32'd5, '0);
      push_op(OP_REMOVE, '0, '0);
      push_op(OP_INSERT, 32'd5, '0);
      push_op(OP_REMOVE, '0, '0);
      push_op(OP_INSERT, 32'd1, '0);

      // zero capacity refuses every insert
      set_capacity(0);
      push_op(OP_INSERT, 32'd9, '0);
      push_op(OP_LOOKUP, '0, 6'd1);
      push_op(OP_REMOVE, '0, '0);
      push_op(OP_REMOVE, '0, '0);
      wait_drained();

      run_phase(127, 0, 0, 250, 60);
      run_phase(64, 82, 0, 200, 45);
      run_phase(1, 0, 82, 150, 45);
      run_phase(17, 38, 38, 200, 50);
      run_phase(64, 0, 0, 200, 35);
      run_phase(100, 82, 0, 250, 60);
      run_phase(0, 0, 82, 50, 30);
      run_phase(33, 38, 38, 250, 50);
      run_phase(64, 0, 0, 200, 50);

      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/slist_pkg.sv
hw/rtl/slist_cell.sv
hw/rtl/slist_chain.sv
hw/rtl/sorted_list_insert_remove_unit.sv
tb/sv/sorted_list_insert_remove_unit_tb.sv
